@@ hw/rtl/gauge_reply_log_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// gauge reply log decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef GAUGE_REPLY_LOG_DECODER_CORE_MACROS_SVH
`define GAUGE_REPLY_LOG_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define GLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/glogdec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glogdec_pkg
// Types, constants and the log threshold table of the gauge reply decoder.
// ----------------------------------------------------------------------------
package glogdec_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MANT_W     = 14;
  localparam int unsigned EXP_W      = 7;
  localparam int unsigned LOG_W      = 14;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SHIFT_W    = 2;
  localparam int unsigned THR_BANK_W = 2;
  localparam int unsigned THR_ROW_W  = 8;
  localparam int unsigned IDX_W      = THR_BANK_W + THR_ROW_W;
  localparam int unsigned SUM_W      = 17;

  localparam logic [POS_W-1:0]  POS_ADDR_FIRST  = 4'd0;
  localparam logic [POS_W-1:0]  POS_ADDR_SECOND = 4'd1;
  localparam logic [POS_W-1:0]  POS_ADDR_THIRD  = 4'd2;
  localparam logic [POS_W-1:0]  POS_MARKER      = 4'd3;
  localparam logic [POS_W-1:0]  POS_EXPONENT    = 4'd8;
  localparam logic [POS_W-1:0]  REPLY_LEN       = 4'd10;

  localparam logic [BYTE_W-1:0] MARKER_CHAR = 8'h4D;
  localparam logic [BYTE_W-1:0] DIGIT_LO    = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI    = 8'h39;

  localparam logic [BYTE_W-1:0] ADDR_FIRST_RST  = 8'd48;
  localparam logic [BYTE_W-1:0] ADDR_SECOND_RST = 8'd48;
  localparam logic [BYTE_W-1:0] ADDR_THIRD_RST  = 8'd49;

  localparam logic [SUM_W-1:0] LOG_DECADE = 17'd600;
  localparam logic [SUM_W-1:0] LOG_BASE   = 17'd1800;
  localparam logic [SUM_W-1:0] LOG_OFFSET = 17'd7000;
  localparam logic [LOG_W-1:0] LOG_MAX    = 14'd12800;

  localparam logic [63:0] LOG_C_FRAC = 64'd11400039846294988685;
  localparam logic [63:0] ROUND_EPS  = 64'd16777216;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_ADDR   = 2'd1,
    ST_FORMAT = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR_FIRST  = 2'd0,
    CFG_ADDR_SECOND = 2'd1,
    CFG_ADDR_THIRD  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    status_e            status;
    logic [MANT_W-1:0]  mant;
    logic [EXP_W-1:0]   expo;
  } reply_t;

  typedef struct packed {
    status_e             status;
    logic [MANT_W-1:0]   mant;
    logic [EXP_W-1:0]    expo;
    logic [MANT_W-1:0]   norm;
    logic [SHIFT_W-1:0]  shift;
    logic [IDX_W-1:0]    idx;
  } srch_t;

  typedef logic [(1<<THR_BANK_W)-1:0][(1<<THR_ROW_W)-1:0][MANT_W-1:0] thr_tab_t;

  // floor(600*log10(m)) by repeated squaring, elaboration only
  function automatic int unsigned log_rom_f(input int unsigned m);
    logic [63:0]  x;
    logic [63:0]  f;
    logic [63:0]  h;
    logic [63:0]  l;
    logic [127:0] p;
    logic [127:0] acc;
    int unsigned  n;
    int           i;
    n = 0;
    while (n < 31 && (m >> (n + 1)) != 0) n++;
    x = 64'(m) << (63 - n);
    f = 64'd0;
    for (i = 0; i < 64; i++) begin
      p = {64'd0, x} * {64'd0, x};
      h = p[127:64];
      l = p[63:0];
      if (h[63]) begin
        x = h;
        f = {f[62:0], 1'b1};
      end else begin
        x = {h[62:0], l[63]};
        f = {f[62:0], 1'b0};
      end
    end
    acc = {64'(180 * n), 64'd0};
    acc = acc + {64'd0, LOG_C_FRAC} * 128'(n);
    acc = acc + {64'd0, f} * 128'd180;
    p   = {64'd0, LOG_C_FRAC} * {64'd0, f};
    acc = acc + {64'd0, p[127:64]};
    acc = acc + {64'd0, ROUND_EPS};
    return acc[95:64];
  endfunction

  // entry 0<j<600: least m in 1000..9999 with floor(600*log10(m))>=1800+j
  function automatic thr_tab_t build_thr_f();
    thr_tab_t    tab;
    int unsigned nxt;
    int unsigned v;
    int unsigned m;
    int unsigned j;
    for (j = 0; j < (1 << IDX_W); j++) begin
      tab[j >> THR_ROW_W][j & ((1 << THR_ROW_W) - 1)] = {MANT_W{1'b1}};
    end
    tab[0][0] = '0;
    nxt = 1;
    for (m = 1000; m <= 9999; m++) begin
      v = log_rom_f(m) - 1800;
      while (nxt <= v && nxt < 600) begin
        tab[nxt >> THR_ROW_W][nxt & ((1 << THR_ROW_W) - 1)] = MANT_W'(m);
        nxt++;
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr_f();

endpackage

@@ hw/rtl/glogdec_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glogdec_in_if
// Reply byte channel: valid/ready handshake carrying one byte and its last flag.
// ----------------------------------------------------------------------------
interface glogdec_in_if;
  logic                              valid;
  logic                              ready;
  logic [glogdec_pkg::BYTE_W-1:0]    rx_byte;
  logic                              end_of_reply;

  modport source (output valid, rx_byte, end_of_reply, input ready);
  modport sink   (input valid, rx_byte, end_of_reply, output ready);
endinterface

@@ hw/rtl/glogdec_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glogdec_out_if
// Result channel: valid/ready handshake carrying status, log value and digits.
// ----------------------------------------------------------------------------
interface glogdec_out_if;
  logic                              valid;
  logic                              ready;
  logic [glogdec_pkg::STAT_W-1:0]    status;
  logic [glogdec_pkg::LOG_W-1:0]     log_value;
  logic [glogdec_pkg::MANT_W-1:0]    mantissa_digits;
  logic [glogdec_pkg::EXP_W-1:0]     exponent_digits;

  modport source (output valid, status, log_value, mantissa_digits, exponent_digits,
                  input ready);
  modport sink   (input valid, status, log_value, mantissa_digits, exponent_digits,
                  output ready);
endinterface

@@ hw/rtl/gauge_reply_log_decoder_core.sv @@
`timescale 1ns / 1ps
// path: reply, normalisation, ten threshold search stage and result registers
// throughput: one request per cycle unless a stall reaches the reply register;
// per-stage valids let bytes in while a finished result waits at the output
// reset: address characters return to their defaults, reply state and all
// pipeline valids clear at once; no clearing pass
// ----------------------------------------------------------------------------
// gauge_reply_log_decoder_core
// Checks a gauge reply byte by byte, decodes mantissa and exponent digits and
// gives a range status and the scaled log pressure on the last byte.
// ----------------------------------------------------------------------------
module gauge_reply_log_decoder_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [glogdec_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [glogdec_pkg::BYTE_W-1:0]         cfg_data_i,
  glogdec_in_if.sink                             req_i,
  glogdec_out_if.source                          res_o
);
  import glogdec_pkg::*;

  localparam int unsigned LEVELS = IDX_W;

  logic [BYTE_W-1:0] addr_first_q, addr_second_q, addr_third_q;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              addr_ok_q, addr_ok_d;
  logic              fmt_ok_q, fmt_ok_d;
  logic [MANT_W-1:0] mant_q, mant_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic              is_digit;
  logic [3:0]        digit;
  logic              accept;
  status_e           entry_status;

  logic              v1_q;
  reply_t            p1_q;
  logic              rdy1;

  logic              sv_q  [0:LEVELS];
  srch_t             srch_q [0:LEVELS];
  logic              rdy   [0:LEVELS];
  srch_t             norm_d;
  logic              above, below;

  logic              out_free;
  logic              res_valid_q;
  status_e           res_status_q;
  logic [LOG_W-1:0]  res_log_q;
  logic [MANT_W-1:0] res_mant_q;
  logic [EXP_W-1:0]  res_exp_q;
  logic [SUM_W-1:0]  log_sum;
  srch_t             fin;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_first_q  <= ADDR_FIRST_RST;
      addr_second_q <= ADDR_SECOND_RST;
      addr_third_q  <= ADDR_THIRD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ADDR_FIRST:  addr_first_q  <= cfg_data_i;
        CFG_ADDR_SECOND: addr_second_q <= cfg_data_i;
        CFG_ADDR_THIRD:  addr_third_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte parser
  assign accept   = req_i.valid && req_i.ready;
  assign is_digit = (req_i.rx_byte >= DIGIT_LO) && (req_i.rx_byte <= DIGIT_HI);
  assign digit    = is_digit ? 4'(req_i.rx_byte - DIGIT_LO) : 4'd0;

  always_comb begin
    pos_d     = pos_q;
    addr_ok_d = addr_ok_q;
    fmt_ok_d  = fmt_ok_q;
    mant_d    = mant_q;
    exp_d     = exp_q;
    if (pos_q == POS_ADDR_FIRST) begin
      addr_ok_d = addr_ok_q && (req_i.rx_byte == addr_first_q);
    end else if (pos_q == POS_ADDR_SECOND) begin
      addr_ok_d = addr_ok_q && (req_i.rx_byte == addr_second_q);
    end else if (pos_q == POS_ADDR_THIRD) begin
      addr_ok_d = addr_ok_q && (req_i.rx_byte == addr_third_q);
    end else if (pos_q == POS_MARKER) begin
      fmt_ok_d = fmt_ok_q && (req_i.rx_byte == MARKER_CHAR);
    end else if (pos_q < POS_EXPONENT) begin
      fmt_ok_d = fmt_ok_q && is_digit;
      mant_d   = (mant_q << 3) + (mant_q << 1) + MANT_W'(digit);
    end else if (pos_q < REPLY_LEN) begin
      fmt_ok_d = fmt_ok_q && is_digit;
      exp_d    = (exp_q << 3) + (exp_q << 1) + EXP_W'(digit);
    end
    if (pos_q < REPLY_LEN) begin
      pos_d = pos_q + 4'd1;
    end
    if (!addr_ok_d) begin
      entry_status = ST_ADDR;
    end else if ((pos_d < REPLY_LEN) || !fmt_ok_d) begin
      entry_status = ST_FORMAT;
    end else begin
      entry_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      addr_ok_q <= 1'b1;
      fmt_ok_q  <= 1'b1;
      mant_q    <= '0;
      exp_q     <= '0;
    end else if (accept) begin
      if (req_i.end_of_reply) begin
        pos_q     <= '0;
        addr_ok_q <= 1'b1;
        fmt_ok_q  <= 1'b1;
        mant_q    <= '0;
        exp_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        addr_ok_q <= addr_ok_d;
        fmt_ok_q  <= fmt_ok_d;
        mant_q    <= mant_d;
        exp_q     <= exp_d;
      end
    end
  end

  // reply register
  assign rdy1        = !v1_q || rdy[0];
  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= accept && req_i.end_of_reply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.end_of_reply) begin
      p1_q.status <= entry_status;
      p1_q.mant   <= mant_d;
      p1_q.expo   <= exp_d;
    end
  end

  // range test and decimal normalisation
  always_comb begin
    if (p1_q.expo <= 7'd9) begin
      above = 1'b0;
    end else if (p1_q.expo >= 7'd14) begin
      above = (p1_q.mant != '0);
    end else if (p1_q.expo == 7'd10) begin
      above = (p1_q.mant > 14'd1000);
    end else if (p1_q.expo == 7'd11) begin
      above = (p1_q.mant > 14'd100);
    end else if (p1_q.expo == 7'd12) begin
      above = (p1_q.mant > 14'd10);
    end else begin
      above = (p1_q.mant > 14'd1);
    end
    if (p1_q.expo <= 7'd29) begin
      below = 1'b1;
    end else if (p1_q.expo >= 7'd33) begin
      below = (p1_q.expo == 7'd33) && (p1_q.mant == '0);
    end else if (p1_q.expo == 7'd30) begin
      below = (p1_q.mant < 14'd1000);
    end else if (p1_q.expo == 7'd31) begin
      below = (p1_q.mant < 14'd100);
    end else begin
      below = (p1_q.mant < 14'd10);
    end

    norm_d.mant = p1_q.mant;
    norm_d.expo = p1_q.expo;
    norm_d.idx  = '0;
    if (p1_q.status != ST_OK) begin
      norm_d.status = p1_q.status;
    end else if (above && below) begin
      norm_d.status = ST_OK;
    end else begin
      norm_d.status = ST_RANGE;
    end
    if (p1_q.mant < 14'd10) begin
      norm_d.norm  = MANT_W'(p1_q.mant * 14'd1000);
      norm_d.shift = 2'd3;
    end else if (p1_q.mant < 14'd100) begin
      norm_d.norm  = MANT_W'(p1_q.mant * 14'd100);
      norm_d.shift = 2'd2;
    end else if (p1_q.mant < 14'd1000) begin
      norm_d.norm  = MANT_W'(p1_q.mant * 14'd10);
      norm_d.shift = 2'd1;
    end else begin
      norm_d.norm  = p1_q.mant;
      norm_d.shift = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      sv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && v1_q) begin
      srch_q[0] <= norm_d;
    end
  end

  // threshold search, one index bit per stage
  assign rdy[LEVELS] = !sv_q[LEVELS] || out_free;

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam logic [IDX_W-1:0] BIT_MASK = IDX_W'(1) << (IDX_W - 1 - k);
    logic [IDX_W-1:0]  cand;
    logic [MANT_W-1:0] thr;
    srch_t             step_d;

    assign rdy[k] = !sv_q[k] || rdy[k+1];
    assign cand   = srch_q[k].idx | BIT_MASK;
    assign thr    = THR_TAB[cand[IDX_W-1 -: THR_BANK_W]][cand[THR_ROW_W-1:0]];

    always_comb begin
      step_d = srch_q[k];
      if (thr <= srch_q[k].norm) begin
        step_d.idx = cand;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && sv_q[k]) begin
        srch_q[k+1] <= step_d;
      end
    end
  end

  // result register
  assign fin      = srch_q[LEVELS];
  assign out_free = !res_valid_q || res_o.ready;
  assign log_sum  = SUM_W'(fin.idx) + SUM_W'(fin.expo) * LOG_DECADE + LOG_BASE
                    - SUM_W'(fin.shift) * LOG_DECADE - LOG_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= sv_q[LEVELS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && sv_q[LEVELS]) begin
      res_status_q <= fin.status;
      res_log_q    <= (fin.status == ST_OK) ? LOG_W'(log_sum) : '0;
      if ((fin.status == ST_OK) || (fin.status == ST_RANGE)) begin
        res_mant_q <= fin.mant;
        res_exp_q  <= fin.expo;
      end else begin
        res_mant_q <= '0;
        res_exp_q  <= '0;
      end
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.status          = res_status_q;
  assign res_o.log_value       = res_log_q;
  assign res_o.mantissa_digits = res_mant_q;
  assign res_o.exponent_digits = res_exp_q;

  `include "gauge_reply_log_decoder_core_macros.svh"

  `GLD_ASSERT_NOW(a_ok_reading, res_o.valid && (res_o.status == ST_OK), (res_o.mantissa_digits != '0) && (res_o.log_value <= LOG_MAX), "ok result with zero mantissa or log value out of range")
  `GLD_ASSERT_NOW(a_bad_zeroed, res_o.valid && ((res_o.status == ST_ADDR) || (res_o.status == ST_FORMAT)), (res_o.log_value == '0) && (res_o.mantissa_digits == '0) && (res_o.exponent_digits == '0), "rejected reply carries nonzero fields")
  `GLD_ASSERT_NEXT(a_last_enters, accept && req_i.end_of_reply, v1_q && (pos_q == POS_ADDR_FIRST), "last byte not queued or parser not cleared")
  `GLD_ASSERT_NEXT(a_tail_holds, sv_q[LEVELS] && !rdy[LEVELS], sv_q[LEVELS] && $stable(srch_q[LEVELS]), "stalled search result lost or changed")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the gauge reply log decoder. Replies go in byte by byte and
// each result is checked field by field against a behavioural decoder in the
// bench or a pinned row. A directed table runs first, then random replies,
// mostly well formed, under several address settings and random handshake stalls.
// ----------------------------------------------------------------------------
module tb;
  import glogdec_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned PHASE_ITEMS  = 52;

  typedef struct packed {
    status_e            status;
    logic [LOG_W-1:0]   logv;
    logic [MANT_W-1:0]  mant;
    logic [EXP_W-1:0]   expo;
  } decoded_t;

  typedef struct {
    string    txt;
    bit       pinned;
    status_e  st;
    int       lg;
    int       mt;
    int       ex;
  } reply_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [BYTE_W-1:0]     cfg_data_i;

  glogdec_in_if  req_if ();
  glogdec_out_if res_if ();

  gauge_reply_log_decoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // decoder state mirrored in the bench
  logic [BYTE_W-1:0]  addr_char [3];
  logic [POS_W-1:0]   rx_pos;
  bit                 addr_ok;
  bit                 fmt_ok;
  logic [MANT_W-1:0]  mant_acc;
  logic [EXP_W-1:0]   exp_acc;

  decoded_t  decoded_q [$];
  int        fail_count;
  int        items_sent;
  int        cycle_count;
  bit        src_idle_on;
  bit        sink_idle_on;

  reply_row_t dir_rows [21] = '{
    '{"001M100023",   1'b1, ST_OK,     8600, 1000, 23},
    '{"001M999929",   1'b0, ST_OK,     0,    0,    0},
    '{"001M099930",   1'b0, ST_OK,     0,    0,    0},
    '{"001M000932",   1'b0, ST_OK,     0,    0,    0},
    '{"001M001032",   1'b1, ST_RANGE,  0,    10,   32},
    '{"001M100010",   1'b1, ST_RANGE,  0,    1000, 10},
    '{"001M100110",   1'b0, ST_OK,     0,    0,    0},
    '{"001M000000",   1'b1, ST_RANGE,  0,    0,    0},
    '{"001M999999",   1'b1, ST_RANGE,  0,    9999, 99},
    '{"001M000114",   1'b1, ST_OK,     1400, 1,    14},
    '{"101M100023",   1'b1, ST_ADDR,   0,    0,    0},
    '{"002M100023",   1'b1, ST_ADDR,   0,    0,    0},
    '{"001N100023",   1'b1, ST_FORMAT, 0,    0,    0},
    '{"001M1A0023",   1'b1, ST_FORMAT, 0,    0,    0},
    '{"001M10002:",   1'b1, ST_FORMAT, 0,    0,    0},
    '{"001M/00023",   1'b1, ST_FORMAT, 0,    0,    0},
    '{"001M12",       1'b1, ST_FORMAT, 0,    0,    0},
    '{"0X",           1'b1, ST_ADDR,   0,    0,    0},
    '{"0",            1'b1, ST_FORMAT, 0,    0,    0},
    '{"001M100023XY", 1'b1, ST_OK,     8600, 1000, 23},
    '{"001M500020",   1'b0, ST_OK,     0,    0,    0}
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // strictly between 1e-10 and 1e10 for a reading of m * 10^(e-23)
  function automatic bit reading_in_range(input int m, input int e);
    bit above;
    bit below;
    if (e <= 13) above = (longint'(m) > pow10(13 - e));
    else above = (m >= 1);
    if (e <= 28) below = 1'b1;
    else if (e <= 33) below = (longint'(m) < pow10(33 - e));
    else below = 1'b0;
    return above && below;
  endfunction

  // floor(600 * log10(m)), nudged so that exact powers of ten land on the integer
  function automatic int log600_floor(input int m);
    real r;
    r = 600.0 * $log10(real'(m));
    return int'($floor(r + 1.0e-7));
  endfunction

  function automatic void clear_reply();
    rx_pos   = '0;
    addr_ok  = 1'b1;
    fmt_ok   = 1'b1;
    mant_acc = '0;
    exp_acc  = '0;
  endfunction

  function automatic void advance_reply(input logic [BYTE_W-1:0] b, input logic last,
                                        output bit has, output decoded_t r);
    bit          digit;
    int          d;
    has      = 1'b0;
    r.status = ST_OK;
    r.logv   = '0;
    r.mant   = '0;
    r.expo   = '0;
    if (rx_pos < POS_MARKER) begin
      if (b != addr_char[rx_pos]) addr_ok = 1'b0;
    end else if (rx_pos == POS_MARKER) begin
      if (b != MARKER_CHAR) fmt_ok = 1'b0;
    end else if (rx_pos < REPLY_LEN) begin
      digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
      d = digit ? int'(b - DIGIT_LO) : 0;
      if (!digit) fmt_ok = 1'b0;
      if (rx_pos < POS_EXPONENT) mant_acc = MANT_W'(int'(mant_acc) * 10 + d);
      else exp_acc = EXP_W'(int'(exp_acc) * 10 + d);
    end
    if (rx_pos < REPLY_LEN) rx_pos = rx_pos + 1'b1;
    if (last) begin
      has = 1'b1;
      if (!addr_ok) begin
        r.status = ST_ADDR;
      end else if (rx_pos < REPLY_LEN || !fmt_ok) begin
        r.status = ST_FORMAT;
      end else begin
        r.mant = mant_acc;
        r.expo = exp_acc;
        if (reading_in_range(int'(mant_acc), int'(exp_acc))) begin
          r.logv = LOG_W'(log600_floor(int'(mant_acc)) + int'(LOG_DECADE) * int'(exp_acc)
                          - int'(LOG_OFFSET));
        end else begin
          r.status = ST_RANGE;
        end
      end
      clear_reply();
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input bit pinned, input decoded_t pinned_val);
    int        gap;
    bit        has;
    decoded_t  r;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.rx_byte      = b;
    req_if.end_of_reply = last;
    do @(posedge clk_i); while (!req_if.ready);
    advance_reply(b, last, has, r);
    if (has) begin
      if (pinned) r = pinned_val;
      decoded_q.push_back(r);
    end
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_addr_char(input cfg_reg_e idx, input logic [BYTE_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    addr_char[idx] = v;
  endtask

  task automatic send_random_reply();
    logic [BYTE_W-1:0]  bytes [$];
    decoded_t           none;
    int                 kind;
    int                 m;
    int                 e;
    int                 len;
    none = '0;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      len = $urandom_range(1, 14);
      repeat (len) bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 9999);
      e = ($urandom_range(0, 9) < 7) ? $urandom_range(8, 35) : $urandom_range(0, 99);
      bytes.push_back(addr_char[0]);
      bytes.push_back(addr_char[1]);
      bytes.push_back(addr_char[2]);
      bytes.push_back(MARKER_CHAR);
      bytes.push_back(DIGIT_LO + BYTE_W'(m / 1000));
      bytes.push_back(DIGIT_LO + BYTE_W'((m / 100) % 10));
      bytes.push_back(DIGIT_LO + BYTE_W'((m / 10) % 10));
      bytes.push_back(DIGIT_LO + BYTE_W'(m % 10));
      bytes.push_back(DIGIT_LO + BYTE_W'(e / 10));
      bytes.push_back(DIGIT_LO + BYTE_W'(e % 10));
      if ($urandom_range(0, 9) == 0)
        bytes[$urandom_range(0, 2)] = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0)
        bytes[3] = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 11) == 0)
        bytes[$urandom_range(4, 9)] = BYTE_W'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, 9);
        while (bytes.size() > len) void'(bytes.pop_back());
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 4)) bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], i == bytes.size() - 1, 1'b0, none);
    end
  endtask

  task automatic check_result();
    decoded_t r;
    if (decoded_q.size() == 0) begin
      $error("result with no request pending");
      fail_count++;
    end else begin
      r = decoded_q.pop_front();
      if (res_if.status != r.status) begin
        $error("status: expected %0d, actual %0d", r.status, res_if.status);
        fail_count++;
      end
      if (res_if.log_value != r.logv) begin
        $error("log_value: expected %0d, actual %0d", r.logv, res_if.log_value);
        fail_count++;
      end
      if (res_if.mantissa_digits != r.mant) begin
        $error("mantissa_digits: expected %0d, actual %0d", r.mant, res_if.mantissa_digits);
        fail_count++;
      end
      if (res_if.exponent_digits != r.expo) begin
        $error("exponent_digits: expected %0d, actual %0d", r.expo, res_if.exponent_digits);
        fail_count++;
      end
    end
  endtask

  initial begin : sink_side
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk_i);
      if (gap != 0) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      check_result();
    end
  end

  initial begin : main_seq
    decoded_t  pinned;
    int        budget;
    req_if.valid        = 1'b0;
    req_if.rx_byte      = '0;
    req_if.end_of_reply = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_ADDR_FIRST;
    cfg_data_i          = '0;
    rst_ni              = 1'b0;
    fail_count          = 0;
    items_sent          = 0;
    src_idle_on         = 1'b0;
    sink_idle_on        = 1'b0;
    addr_char[0] = ADDR_FIRST_RST;
    addr_char[1] = ADDR_SECOND_RST;
    addr_char[2] = ADDR_THIRD_RST;
    clear_reply();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k]) begin
      src_idle_on   = $urandom_range(0, 1);
      sink_idle_on  = $urandom_range(0, 1);
      pinned.status = dir_rows[k].st;
      pinned.logv   = LOG_W'(dir_rows[k].lg);
      pinned.mant   = MANT_W'(dir_rows[k].mt);
      pinned.expo   = EXP_W'(dir_rows[k].ex);
      for (int i = 0; i < dir_rows[k].txt.len(); i++) begin
        send_byte(dir_rows[k].txt[i], i == dir_rows[k].txt.len() - 1,
                  dir_rows[k].pinned, pinned);
      end
    end
    wait_drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_addr_char(CFG_ADDR_FIRST, 8'h00);
          write_addr_char(CFG_ADDR_SECOND, 8'h00);
          write_addr_char(CFG_ADDR_THIRD, 8'h00);
        end
        2: begin
          write_addr_char(CFG_ADDR_FIRST, 8'hFF);
          write_addr_char(CFG_ADDR_SECOND, 8'hFF);
          write_addr_char(CFG_ADDR_THIRD, 8'hFF);
        end
        3: begin
          write_addr_char(CFG_ADDR_FIRST, BYTE_W'($urandom_range(0, 255)));
          write_addr_char(CFG_ADDR_SECOND, BYTE_W'($urandom_range(0, 255)));
          write_addr_char(CFG_ADDR_THIRD, BYTE_W'($urandom_range(0, 255)));
        end
        4: begin
          write_addr_char(CFG_ADDR_FIRST, BYTE_W'($urandom_range(33, 126)));
          write_addr_char(CFG_ADDR_SECOND, BYTE_W'($urandom_range(33, 126)));
          write_addr_char(CFG_ADDR_THIRD, BYTE_W'($urandom_range(33, 126)));
        end
        default: begin
        end
      endcase
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        send_random_reply();
        // hold off until the output side has caught up
        if ($urandom_range(0, 19) == 0) wait_drain();
      end
      wait_drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
